FILE: sv/rsa_mexp_pkg.sv
// package for the modular exponentiation block: payload widths, register
// indexes, opcodes and the microcode program of the sequencer
// no dependencies
package rsa_mexp_pkg;

  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned RESULT_W  = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned UADDR_W   = 3;

  localparam int unsigned MODULUS_RST  = 3233;
  localparam int unsigned PUB_EXP_RST  = 17;
  localparam int unsigned PRIV_EXP_RST = 2753;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODULUS  = 2'd0,
    REG_PUB_EXP  = 2'd1,
    REG_PRIV_EXP = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } opcode_e;

  // jump conditions of a control word
  typedef enum logic [2:0] {
    COND_NONE      = 3'd0,
    COND_NO_IN     = 3'd1,
    COND_MUL_BUSY  = 3'd2,
    COND_MORE_BITS = 3'd3,
    COND_OUT_BUSY  = 3'd4
  } cond_e;

  typedef logic [UADDR_W-1:0] uaddr_t;

  localparam uaddr_t UA_WAIT   = 3'd0;
  localparam uaddr_t UA_REDUCE = 3'd1;
  localparam uaddr_t UA_SQ0    = 3'd2;
  localparam uaddr_t UA_MUL    = 3'd3;
  localparam uaddr_t UA_UPD    = 3'd4;
  localparam uaddr_t UA_EMIT   = 3'd5;

  typedef struct packed {
    logic   ld_item;   // take an input item, acc = 1
    logic   setup;     // clear partials, load multiplier shift registers
    logic   run_mul;   // one bit step of both modular multipliers
    logic   mb_one;    // multiplicand of unit b is one (base reduction)
    logic   wr_acc;    // acc takes unit a product when exponent bit is set
    logic   wr_sq;     // sq takes unit b product
    logic   shift_exp; // move to next exponent bit
    logic   emit;      // write the output register
    cond_e  cond;
    uaddr_t target;    // taken when cond holds
    uaddr_t next;      // taken otherwise
  } uword_t;

  function automatic uword_t urom(input uaddr_t addr);
    uword_t w;
    w = '{ld_item: 1'b0, setup: 1'b0, run_mul: 1'b0, mb_one: 1'b0, wr_acc: 1'b0,
           wr_sq: 1'b0, shift_exp: 1'b0, emit: 1'b0, cond: COND_NONE,
           target: UA_WAIT, next: UA_WAIT};
    case (addr)
      UA_WAIT: begin
        w.ld_item = 1'b1;
        w.setup   = 1'b1;
        w.cond    = COND_NO_IN;
        w.target  = UA_WAIT;
        w.next    = UA_REDUCE;
      end
      UA_REDUCE: begin
        w.run_mul = 1'b1;
        w.mb_one  = 1'b1;
        w.cond    = COND_MUL_BUSY;
        w.target  = UA_REDUCE;
        w.next    = UA_SQ0;
      end
      UA_SQ0: begin
        w.wr_sq = 1'b1;
        w.setup = 1'b1;
        w.next  = UA_MUL;
      end
      UA_MUL: begin
        w.run_mul = 1'b1;
        w.cond    = COND_MUL_BUSY;
        w.target  = UA_MUL;
        w.next    = UA_UPD;
      end
      UA_UPD: begin
        w.wr_acc    = 1'b1;
        w.wr_sq     = 1'b1;
        w.setup     = 1'b1;
        w.shift_exp = 1'b1;
        w.cond      = COND_MORE_BITS;
        w.target    = UA_MUL;
        w.next      = UA_EMIT;
      end
      UA_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = COND_OUT_BUSY;
        w.target = UA_EMIT;
        w.next   = UA_WAIT;
      end
      default: begin
        w.next = UA_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

FILE: sv/rsa_mexp_if.sv
// valid/ready channel interfaces of the modular exponentiation block:
// input items, result items and configuration writes
// depends on rsa_mexp_pkg
interface rsa_mexp_in_if;
  logic                                valid;
  logic                                ready;
  logic                                opcode;
  logic [rsa_mexp_pkg::VALUE_W-1:0]    value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface rsa_mexp_out_if;
  logic                                valid;
  logic                                ready;
  logic [rsa_mexp_pkg::RESULT_W-1:0]   result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

interface rsa_mexp_cfg_if #(parameter int unsigned DATA_W = 16);
  logic                                valid;
  logic                                ready;
  logic [rsa_mexp_pkg::CFG_IDX_W-1:0]  index;
  logic [DATA_W-1:0]                   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/rsa_modular_exponentiation.sv
// modular exponentiation (value ^ exponent mod modulus), right-to-left
// square-and-multiply under a microcoded sequencer
// depends on rsa_mexp_pkg and rsa_mexp_if
//
// usage:
//   cfg_i  : register writes (0 modulus, 1 public exponent, 2 private
//            exponent), always ready; write only while the block is idle;
//            writes to index 3 are dropped
//   in_i   : one item = opcode (0 encrypt with public, 1 decrypt with
//            private exponent) and a 16-bit value; ready only while the
//            sequencer sits at its wait step
//   out_o  : one result per item from an output register
// timing: two bit-serial modular multipliers run side by side, one bit of
//   the multiplier per cycle. the base is reduced first, then each of the
//   WORD_BITS exponent bits takes one multiplication on each unit; the next
//   item is taken only after the result is written to the output register
// reset: registers return to 3233 / 17 / 2753, sequencer to its wait step,
//   output empty. if the receiver stalls, the result holds and the
//   sequencer waits at its emit step until the output register frees up
module rsa_modular_exponentiation #(
  parameter int unsigned WORD_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  rsa_mexp_cfg_if.sink              cfg_i,
  rsa_mexp_in_if.sink               in_i,
  rsa_mexp_out_if.source            out_o
);

  localparam int unsigned W     = WORD_BITS;
  localparam int unsigned CNT_W = $clog2(WORD_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);

  // configuration registers
  logic [W-1:0] modulus_q, pub_exp_q, priv_exp_q;

  // sequencer
  rsa_mexp_pkg::uaddr_t pc_q, pc_d;
  rsa_mexp_pkg::uword_t uw;
  logic                 cond_hit;

  // datapath
  logic [W-1:0]     acc_q, acc_d, sq_q, sq_d, exp_q, exp_d;
  logic [W-1:0]     pa_q, pa_d, pb_q, pb_d, ba_q, ba_d, bb_q, bb_d;
  logic [W-1:0]     mb_sel;
  logic [CNT_W-1:0] cnt_q, cnt_d, ebit_q, ebit_d;

  logic in_ready, in_fire, out_busy, emit_fire;
  logic out_valid_q, out_valid_d;
  logic [rsa_mexp_pkg::RESULT_W-1:0] result_q, result_d;

  // one step of interleaved modular multiplication: r = (2r + bit*a) mod m,
  // with r < m and a <= m so at most two subtractions are needed
  function automatic logic [W-1:0] mod_step(input logic [W-1:0] r,
                                            input logic [W-1:0] a,
                                            input logic         b,
                                            input logic [W-1:0] m);
    logic [W+2:0] t, d1, d2;
    t  = {2'b00, r, 1'b0} + (b ? {3'b000, a} : '0);
    d1 = t - {3'b000, m};
    d2 = t - {2'b00, m, 1'b0};
    if (!d2[W+2]) begin
      return d2[W-1:0];
    end else if (!d1[W+2]) begin
      return d1[W-1:0];
    end
    return t[W-1:0];
  endfunction

  assign uw        = rsa_mexp_pkg::urom(pc_q);
  assign in_ready  = uw.ld_item;
  assign in_fire   = in_i.valid && in_ready;
  assign out_busy  = out_valid_q && !out_o.ready;
  assign emit_fire = uw.emit && !out_busy;

  always_comb begin
    case (uw.cond)
      rsa_mexp_pkg::COND_NONE:      cond_hit = 1'b0;
      rsa_mexp_pkg::COND_NO_IN:     cond_hit = !in_fire;
      rsa_mexp_pkg::COND_MUL_BUSY:  cond_hit = (cnt_q != '0);
      rsa_mexp_pkg::COND_MORE_BITS: cond_hit = (ebit_q != '0);
      rsa_mexp_pkg::COND_OUT_BUSY:  cond_hit = out_busy;
      default:                      cond_hit = 1'b0;
    endcase
    pc_d = cond_hit ? uw.target : uw.next;
  end

  always_comb begin
    acc_d  = acc_q;
    sq_d   = sq_q;
    exp_d  = exp_q;
    ebit_d = ebit_q;
    pa_d   = pa_q;
    pb_d   = pb_q;
    ba_d   = ba_q;
    bb_d   = bb_q;
    cnt_d  = cnt_q;
    mb_sel = uw.mb_one ? W'(1) : sq_q;

    if (uw.ld_item && in_fire) begin
      acc_d  = W'(1);
      exp_d  = (in_i.opcode == rsa_mexp_pkg::OP_DECRYPT) ? priv_exp_q : pub_exp_q;
      ebit_d = CNT_LAST;
    end
    if (uw.wr_acc && exp_q[0]) begin
      acc_d = pa_q;
    end
    if (uw.wr_sq) begin
      sq_d = pb_q;
    end
    if (uw.shift_exp) begin
      exp_d  = exp_q >> 1;
      ebit_d = ebit_q - CNT_W'(1);
    end

    if (uw.run_mul) begin
      pa_d  = mod_step(pa_q, sq_q, ba_q[W-1], modulus_q);
      pb_d  = mod_step(pb_q, mb_sel, bb_q[W-1], modulus_q);
      ba_d  = ba_q << 1;
      bb_d  = bb_q << 1;
      cnt_d = cnt_q - CNT_W'(1);
    end
    // unit a multiplies acc by sq, unit b squares sq or reduces the base
    if (uw.setup) begin
      pa_d  = '0;
      pb_d  = '0;
      ba_d  = acc_d;
      bb_d  = uw.ld_item ? W'(in_i.value) : pb_q;
      cnt_d = CNT_LAST;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    result_d    = result_q;
    if (emit_fire) begin
      out_valid_d = 1'b1;
      result_d    = (modulus_q == '0) ? '0 : rsa_mexp_pkg::RESULT_W'(acc_q);
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= rsa_mexp_pkg::UA_WAIT;
      out_valid_q <= 1'b0;
      modulus_q   <= W'(rsa_mexp_pkg::MODULUS_RST);
      pub_exp_q   <= W'(rsa_mexp_pkg::PUB_EXP_RST);
      priv_exp_q  <= W'(rsa_mexp_pkg::PRIV_EXP_RST);
    end else begin
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid) begin
        case (cfg_i.index)
          rsa_mexp_pkg::REG_MODULUS:  modulus_q  <= cfg_i.data;
          rsa_mexp_pkg::REG_PUB_EXP:  pub_exp_q  <= cfg_i.data;
          rsa_mexp_pkg::REG_PRIV_EXP: priv_exp_q <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    sq_q     <= sq_d;
    exp_q    <= exp_d;
    ebit_q   <= ebit_d;
    pa_q     <= pa_d;
    pb_q     <= pb_d;
    ba_q     <= ba_d;
    bb_q     <= bb_d;
    cnt_q    <= cnt_d;
    result_q <= result_d;
  end

  assign cfg_i.ready  = 1'b1;
  assign in_i.ready   = in_ready;
  assign out_o.valid  = out_valid_q;
  assign out_o.result = result_q;

endmodule
